### hdl/abs_pkg.sv
// Shared types and constants of the ambient brightness smoother.
package abs_pkg;

   // Field widths
   localparam int TIME_BITS    = 32;
   localparam int AMBIENT_BITS = 10;
   localparam int FRAC_BITS    = 16;
   localparam int CAP_BITS     = 8;
   localparam int OUT_BITS     = 8;
   localparam int CSR_DATA_BITS  = 32;
   localparam int CSR_INDEX_BITS = 3;

   // Time comparison runs a few bits of each stamp per cycle
   localparam int TIME_DIGIT_BITS = 4;
   localparam int TIME_DIGITS     = TIME_BITS / TIME_DIGIT_BITS;
   localparam int TIME_CNT_BITS   = $clog2(TIME_DIGITS);

   // Level arithmetic
   localparam int UPDATE_PERIOD_MS = 50;
   localparam int FRAC_ONE    = (2 ** FRAC_BITS) - 1;
   localparam int FRAC_UNIT   = 2 ** FRAC_BITS;
   localparam int SNAP_THRESH = FRAC_ONE / 100;
   localparam int GAIN_NEW    = (15 * FRAC_UNIT + 50) / 100;
   localparam int GAIN_OLD    = FRAC_UNIT - GAIN_NEW;
   localparam int GLIDE_CNT_BITS = $clog2(FRAC_BITS);

   // Target: round(ambient * FRAC_ONE / ADC_MAX) split as
   // ambient * 2^COARSE_SHIFT plus a short quotient of a serial divide
   localparam int ADC_MAX      = (2 ** AMBIENT_BITS) - 1;
   localparam int ADC_SPAN     = 2 * ADC_MAX;
   localparam int COARSE_SHIFT = FRAC_BITS - AMBIENT_BITS;
   localparam int FINE_MUL     = 2 * (FRAC_ONE - ADC_MAX * (2 ** COARSE_SHIFT));
   localparam int DIV_STEPS    = COARSE_SHIFT;
   localparam int DIV_BITS     = FRAC_BITS + 1;
   localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

   // Output scaling lanes
   localparam int SCALE_LANES    = 3;
   localparam int LANE_BACKLIGHT = 0;
   localparam int LANE_SEGMENT   = 1;
   localparam int LANE_BAR       = 2;
   localparam int SCALE_CNT_BITS = $clog2(CAP_BITS);

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AUTO_ENABLE     = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SAMPLE_INTERVAL = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BACKLIGHT_CAP   = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SEGMENT_CAP     = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BAR_CAP         = 3'd4;

   // Register reset values
   localparam logic [TIME_BITS-1:0] SAMPLE_INTERVAL_RESET = 32'd1000;
   localparam logic [CAP_BITS-1:0]  CAP_RESET             = 8'd255;

   typedef struct packed {
      logic [TIME_BITS-1:0]    now_ms;
      logic [AMBIENT_BITS-1:0] ambient;
   } req_word_type;

   typedef struct packed {
      logic [OUT_BITS-1:0] backlight_level;
      logic [OUT_BITS-1:0] segment_level;
      logic [OUT_BITS-1:0] bar_level;
      logic                settling;
   } rsp_word_type;

endpackage

### hdl/abs_time_cmp.sv
// Digit-serial check that a wrapped time difference reaches a limit.
module abs_time_cmp (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [abs_pkg::TIME_BITS-1:0]  now_ms,
   input  logic [abs_pkg::TIME_BITS-1:0]  last_ms,
   input  logic [abs_pkg::TIME_BITS-1:0]  limit_ms,
   output logic                           done,
   output logic                           at_least
);

   localparam int DB = abs_pkg::TIME_DIGIT_BITS;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic                                ge_ff, ge_in;
   logic [abs_pkg::TIME_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic                                bw1_ff, bw1_in;
   logic                                bw2_ff, bw2_in;
   logic [abs_pkg::TIME_BITS-1:0]       now_sr_ff, now_sr_in;
   logic [abs_pkg::TIME_BITS-1:0]       last_sr_ff, last_sr_in;
   logic [abs_pkg::TIME_BITS-1:0]       lim_sr_ff, lim_sr_in;
   logic [DB:0]                         diff1;
   logic [DB:0]                         diff2;

   // One digit of (now - last) and of (difference - limit)
   assign diff1 = {1'b0, now_sr_ff[DB-1:0]} - {1'b0, last_sr_ff[DB-1:0]}
                  - {{DB{1'b0}}, bw1_ff};
   assign diff2 = {1'b0, diff1[DB-1:0]} - {1'b0, lim_sr_ff[DB-1:0]}
                  - {{DB{1'b0}}, bw2_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      ge_in      = ge_ff;
      cnt_in     = cnt_ff;
      bw1_in     = bw1_ff;
      bw2_in     = bw2_ff;
      now_sr_in  = now_sr_ff;
      last_sr_in = last_sr_ff;
      lim_sr_in  = lim_sr_ff;
      if (start) begin
         // load operands, clear borrows
         busy_in    = 1'b1;
         cnt_in     = '0;
         bw1_in     = 1'b0;
         bw2_in     = 1'b0;
         now_sr_in  = now_ms;
         last_sr_in = last_ms;
         lim_sr_in  = limit_ms;
      end else if (busy_ff) begin
         // advance one digit, least significant first
         bw1_in     = diff1[DB];
         bw2_in     = diff2[DB];
         now_sr_in  = now_sr_ff >> DB;
         last_sr_in = last_sr_ff >> DB;
         lim_sr_in  = lim_sr_ff >> DB;
         cnt_in     = cnt_ff + 1'b1;
         if (cnt_ff == abs_pkg::TIME_CNT_BITS'(abs_pkg::TIME_DIGITS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            ge_in   = ~diff2[DB];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      ge_ff      <= ge_in;
      bw1_ff     <= bw1_in;
      bw2_ff     <= bw2_in;
      now_sr_ff  <= now_sr_in;
      last_sr_ff <= last_sr_in;
      lim_sr_ff  <= lim_sr_in;
   end

   assign done     = done_ff;
   assign at_least = ge_ff;

endmodule

### hdl/abs_target_div.sv
// Serial restoring divide that turns a light sample into a target level.
module abs_target_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [abs_pkg::AMBIENT_BITS-1:0]  ambient,
   output logic [abs_pkg::FRAC_BITS-1:0]     target
);

   localparam int DW = abs_pkg::DIV_BITS;
   localparam int QW = abs_pkg::DIV_STEPS;
   localparam logic [DW-1:0] DVS_START = DW'(abs_pkg::ADC_SPAN * (2 ** (QW - 1)));

   logic                               busy_ff, busy_in;
   logic [abs_pkg::DIV_CNT_BITS-1:0]   cnt_ff, cnt_in;
   logic [DW-1:0]                      rem_ff, rem_in;
   logic [DW-1:0]                      dvs_ff, dvs_in;
   logic [QW-1:0]                      quo_ff, quo_in;
   logic [abs_pkg::AMBIENT_BITS-1:0]   amb_ff, amb_in;
   logic [DW-1:0]                      dividend;

   // Rounding numerator of the fine part: FINE_MUL * ambient + ADC_MAX
   assign dividend = DW'(ambient) * DW'(abs_pkg::FINE_MUL) + DW'(abs_pkg::ADC_MAX);

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      amb_in  = amb_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = dividend;
         dvs_in  = DVS_START;
         quo_in  = '0;
         amb_in  = ambient;
      end else if (busy_ff) begin
         // one quotient bit per cycle
         if (rem_ff >= dvs_ff) begin
            rem_in = rem_ff - dvs_ff;
            quo_in = {quo_ff[QW-2:0], 1'b1};
         end else begin
            quo_in = {quo_ff[QW-2:0], 1'b0};
         end
         dvs_in = dvs_ff >> 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == abs_pkg::DIV_CNT_BITS'(QW - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
      amb_ff <= amb_in;
   end

   // Coarse part is the sample shifted up, fine part the quotient
   assign target = {amb_ff, {abs_pkg::COARSE_SHIFT{1'b0}}}
                   + {{(abs_pkg::FRAC_BITS - QW){1'b0}}, quo_ff};

endmodule

### hdl/abs_glide_mul.sv
// Bit-serial weighted blend of target and level for the glide step.
module abs_glide_mul (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [abs_pkg::FRAC_BITS-1:0]  target,
   input  logic [abs_pkg::FRAC_BITS-1:0]  level,
   output logic                           done,
   output logic [abs_pkg::FRAC_BITS-1:0]  blend
);

   localparam int FB = abs_pkg::FRAC_BITS;
   localparam logic [FB-1:0] GAIN_NEW_C = FB'(abs_pkg::GAIN_NEW);
   localparam logic [FB-1:0] GAIN_OLD_C = FB'(abs_pkg::GAIN_OLD);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [abs_pkg::GLIDE_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [FB-1:0]                       tgt_sr_ff, tgt_sr_in;
   logic [FB-1:0]                       lvl_sr_ff, lvl_sr_in;
   logic [FB:0]                         acc_ff, acc_in;
   logic [FB-1:0]                       add_new;
   logic [FB-1:0]                       add_old;
   logic [FB+1:0]                       sum;

   // Add both partial products of this bit, then drop the bit below
   assign add_new = tgt_sr_ff[0] ? GAIN_NEW_C : '0;
   assign add_old = lvl_sr_ff[0] ? GAIN_OLD_C : '0;
   assign sum     = {1'b0, acc_ff} + {2'b00, add_new} + {2'b00, add_old};

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      tgt_sr_in = tgt_sr_ff;
      lvl_sr_in = lvl_sr_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         tgt_sr_in = target;
         lvl_sr_in = level;
         acc_in    = '0;
      end else if (busy_ff) begin
         acc_in    = sum[FB+1:1];
         tgt_sr_in = tgt_sr_ff >> 1;
         lvl_sr_in = lvl_sr_ff >> 1;
         cnt_in    = cnt_ff + 1'b1;
         if (cnt_ff == abs_pkg::GLIDE_CNT_BITS'(FB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      tgt_sr_ff <= tgt_sr_in;
      lvl_sr_ff <= lvl_sr_in;
      acc_ff    <= acc_in;
   end

   assign done  = done_ff;
   assign blend = acc_ff[FB-1:0];

endmodule

### hdl/abs_scale_mul.sv
// Bit-serial scaling of the level by each brightness cap, one lane per output.
module abs_scale_mul (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 start,
   input  logic [abs_pkg::FRAC_BITS-1:0]                        level,
   input  logic [abs_pkg::SCALE_LANES-1:0][abs_pkg::CAP_BITS-1:0] caps,
   output logic                                                 done,
   output logic [abs_pkg::SCALE_LANES-1:0][abs_pkg::OUT_BITS-1:0] levels
);

   localparam int FB = abs_pkg::FRAC_BITS;
   localparam int NL = abs_pkg::SCALE_LANES;
   localparam int CB = abs_pkg::CAP_BITS;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [abs_pkg::SCALE_CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic [FB-1:0]                       lvl_ff, lvl_in;
   logic [NL-1:0][CB-1:0]               cap_sr_ff, cap_sr_in;
   logic [NL-1:0][FB-1:0]               acc_ff, acc_in;
   logic [NL-1:0][FB:0]                 sum;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      lvl_in    = lvl_ff;
      cap_sr_in = cap_sr_ff;
      acc_in    = acc_ff;
      for (int l = 0; l < NL; l++) begin
         sum[l] = {1'b0, acc_ff[l]} + (cap_sr_ff[l][0] ? {1'b0, lvl_ff} : '0);
      end
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = '0;
         lvl_in    = level;
         cap_sr_in = caps;
         acc_in    = '0;
      end else if (busy_ff) begin
         // add the level where the cap bit is set, then shift down
         for (int l = 0; l < NL; l++) begin
            acc_in[l]    = sum[l][FB:1];
            cap_sr_in[l] = cap_sr_ff[l] >> 1;
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == abs_pkg::SCALE_CNT_BITS'(CB - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      lvl_ff    <= lvl_in;
      cap_sr_ff <= cap_sr_in;
      acc_ff    <= acc_in;
   end

   // Accumulator holds level*cap >> CAP_BITS; take the byte above
   always_comb begin
      for (int l = 0; l < NL; l++) begin
         levels[l] = acc_ff[l][FB-1:FB-abs_pkg::OUT_BITS];
      end
   end

   assign done = done_ff;

endmodule

### hdl/ambient_brightness_smoother_core.sv
// Ambient brightness smoother: time checks, target divide, glide and output scaling.
// An accepted word runs the time checks; if an update is due, the level snaps or glides
// by the bit-serial blend, is scaled, and the result waits while rsp_stall holds the output.
// One word at a time: the next word is accepted in the cycle after the result is loaded,
// when the time checks find no update due, and the cycle after a word taken while disabled.
// Synchronous reset clears the control and smoother state and loads the register defaults.
module ambient_brightness_smoother_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  abs_pkg::req_word_type                req_word,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output abs_pkg::rsp_word_type                rsp_word,
   input  logic                                 csr_write_en,
   input  logic [abs_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [abs_pkg::CSR_DATA_BITS-1:0]    csr_wdata
);

   localparam int TB = abs_pkg::TIME_BITS;
   localparam int FB = abs_pkg::FRAC_BITS;
   localparam int CB = abs_pkg::CAP_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TIME,
      ST_DECIDE,
      ST_GLIDE,
      ST_SCALE,
      ST_EMIT
   } state_type;

   state_type                     state_ff, state_in;

   // Configuration
   logic                          auto_enable_ff, auto_enable_in;
   logic [TB-1:0]                 interval_ff, interval_in;
   logic [CB-1:0]                 backlight_cap_ff, backlight_cap_in;
   logic [CB-1:0]                 segment_cap_ff, segment_cap_in;
   logic [CB-1:0]                 bar_cap_ff, bar_cap_in;

   // Smoother state
   logic [TB-1:0]                 last_sample_ff, last_sample_in;
   logic [TB-1:0]                 last_update_ff, last_update_in;
   logic                          settling_ff, settling_in;
   logic [FB-1:0]                 target_ff, target_in;
   logic [FB-1:0]                 level_ff, level_in;

   // Sequencing
   logic                          cmp_start_ff, cmp_start_in;
   logic                          glide_start_ff, glide_start_in;
   logic                          scale_start_ff, scale_start_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   abs_pkg::rsp_word_type         rsp_word_ff, rsp_word_in;
   logic [TB-1:0]                 now_ff, now_in;
   logic [abs_pkg::AMBIENT_BITS-1:0] amb_ff, amb_in;

   // Unit results
   logic                          sample_done;
   logic                          sample_due;
   logic                          update_done;
   logic                          update_due;
   logic [FB-1:0]                 div_target;
   logic                          glide_done;
   logic [FB-1:0]                 glide_level;
   logic                          scale_done;
   logic [abs_pkg::SCALE_LANES-1:0][CB-1:0]              caps;
   logic [abs_pkg::SCALE_LANES-1:0][abs_pkg::OUT_BITS-1:0] scaled;
   logic [FB-1:0]                 level_gap;

   abs_time_cmp u_sample_cmp (
      .clock    (clock),
      .reset    (reset),
      .start    (cmp_start_ff),
      .now_ms   (now_ff),
      .last_ms  (last_sample_ff),
      .limit_ms (interval_ff),
      .done     (sample_done),
      .at_least (sample_due)
   );

   abs_time_cmp u_update_cmp (
      .clock    (clock),
      .reset    (reset),
      .start    (cmp_start_ff),
      .now_ms   (now_ff),
      .last_ms  (last_update_ff),
      .limit_ms (TB'(abs_pkg::UPDATE_PERIOD_MS)),
      .done     (update_done),
      .at_least (update_due)
   );

   // Finishes before the time checks, which run longer
   abs_target_div u_target_div (
      .clock   (clock),
      .reset   (reset),
      .start   (cmp_start_ff),
      .ambient (amb_ff),
      .target  (div_target)
   );

   abs_glide_mul u_glide_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (glide_start_ff),
      .target (target_ff),
      .level  (level_ff),
      .done   (glide_done),
      .blend  (glide_level)
   );

   always_comb begin
      caps[abs_pkg::LANE_BACKLIGHT] = backlight_cap_ff;
      caps[abs_pkg::LANE_SEGMENT]   = segment_cap_ff;
      caps[abs_pkg::LANE_BAR]       = bar_cap_ff;
   end

   abs_scale_mul u_scale_mul (
      .clock  (clock),
      .reset  (reset),
      .start  (scale_start_ff),
      .level  (level_ff),
      .caps   (caps),
      .done   (scale_done),
      .levels (scaled)
   );

   // Distance between level and target
   assign level_gap = (level_ff >= target_ff) ? (level_ff - target_ff)
                                               : (target_ff - level_ff);

   always_comb begin
      state_in         = state_ff;
      auto_enable_in   = auto_enable_ff;
      interval_in      = interval_ff;
      backlight_cap_in = backlight_cap_ff;
      segment_cap_in   = segment_cap_ff;
      bar_cap_in       = bar_cap_ff;
      last_sample_in   = last_sample_ff;
      last_update_in   = last_update_ff;
      settling_in      = settling_ff;
      target_in        = target_ff;
      level_in         = level_ff;
      cmp_start_in     = 1'b0;
      glide_start_in   = 1'b0;
      scale_start_in   = 1'b0;
      rsp_valid_in     = rsp_valid_ff;
      rsp_word_in      = rsp_word_ff;
      now_in           = now_ff;
      amb_in           = amb_ff;

      // Drop the result word once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      // Register writes
      if (csr_write_en) begin
         case (csr_index)
            abs_pkg::CSR_AUTO_ENABLE:     auto_enable_in   = csr_wdata[0];
            abs_pkg::CSR_SAMPLE_INTERVAL: interval_in      = csr_wdata[TB-1:0];
            abs_pkg::CSR_BACKLIGHT_CAP:   backlight_cap_in = csr_wdata[CB-1:0];
            abs_pkg::CSR_SEGMENT_CAP:     segment_cap_in   = csr_wdata[CB-1:0];
            abs_pkg::CSR_BAR_CAP:         bar_cap_in       = csr_wdata[CB-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // Take a word; ignore it while disabled
            if (req_valid && auto_enable_ff) begin
               now_in       = req_word.now_ms;
               amb_in       = req_word.ambient;
               cmp_start_in = 1'b1;
               state_in     = ST_TIME;
            end
         end
         ST_TIME: begin
            if (sample_done) begin
               if (sample_due && !settling_ff) begin
                  last_sample_in = now_ff;
                  target_in      = div_target;
               end
               if (update_done && update_due) begin
                  last_update_in = now_ff;
                  state_in       = ST_DECIDE;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DECIDE: begin
            // Glide when far from the target, otherwise snap
            if (level_gap > FB'(abs_pkg::SNAP_THRESH)) begin
               glide_start_in = 1'b1;
               state_in       = ST_GLIDE;
            end else begin
               level_in       = target_ff;
               settling_in    = 1'b0;
               scale_start_in = 1'b1;
               state_in       = ST_SCALE;
            end
         end
         ST_GLIDE: begin
            if (glide_done) begin
               level_in       = glide_level;
               settling_in    = 1'b1;
               scale_start_in = 1'b1;
               state_in       = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in                = 1'b1;
               rsp_word_in.backlight_level = scaled[abs_pkg::LANE_BACKLIGHT];
               rsp_word_in.segment_level   = scaled[abs_pkg::LANE_SEGMENT];
               rsp_word_in.bar_level       = scaled[abs_pkg::LANE_BAR];
               rsp_word_in.settling        = settling_ff;
               state_in                    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         auto_enable_ff   <= 1'b0;
         interval_ff      <= abs_pkg::SAMPLE_INTERVAL_RESET;
         backlight_cap_ff <= abs_pkg::CAP_RESET;
         segment_cap_ff   <= abs_pkg::CAP_RESET;
         bar_cap_ff       <= abs_pkg::CAP_RESET;
         last_sample_ff   <= '0;
         last_update_ff   <= '0;
         settling_ff      <= 1'b0;
         target_ff        <= '0;
         level_ff         <= '0;
         cmp_start_ff     <= 1'b0;
         glide_start_ff   <= 1'b0;
         scale_start_ff   <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         auto_enable_ff   <= auto_enable_in;
         interval_ff      <= interval_in;
         backlight_cap_ff <= backlight_cap_in;
         segment_cap_ff   <= segment_cap_in;
         bar_cap_ff       <= bar_cap_in;
         last_sample_ff   <= last_sample_in;
         last_update_ff   <= last_update_in;
         settling_ff      <= settling_in;
         target_ff        <= target_in;
         level_ff         <= level_in;
         cmp_start_ff     <= cmp_start_in;
         glide_start_ff   <= glide_start_in;
         scale_start_ff   <= scale_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
      now_ff      <= now_in;
      amb_ff      <= amb_in;
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule
